// ===== rtl/rxm_pkg.sv =====
`default_nettype none
package rxm_pkg;

    localparam int IN_BITS             = 16;
    localparam int VAL_BITS            = 20;
    localparam int N_CHR               = 8;
    localparam int TDATA_IN_W          = 128;
    localparam int TDATA_OUT_W         = 64;
    localparam int TUSER_OUT_W         = 3;
    localparam int DEF_INPUT_FRAC_BITS = 16;
    localparam int DEF_OUTPUT_INT_BITS = 4;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_WHITE = 2'd3;

    typedef struct packed {
        logic vld;
        logic sing;
    } t_ctl;

    // signed width of one matrix or white entry (x, y or 1 - x - y)
    function automatic int rxm_mw(input int f);
        return ((f > 17) ? f : 17) + 2;
    endfunction

    function automatic int rxm_aw(input int f);
        return 2 * rxm_mw(f) + 1;
    endfunction

    // width of the determinant and of the scale numerators
    function automatic int rxm_dw(input int f);
        return rxm_aw(f) + rxm_mw(f) + 2;
    endfunction

    function automatic int rxm_numw(input int f, input int oi);
        return rxm_dw(f) + rxm_mw(f) + (VAL_BITS - oi);
    endfunction

    function automatic int rxm_denw(input int f);
        return rxm_dw(f) + rxm_mw(f);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rxm_front.sv =====
`default_nettype none
module rxm_front
    import rxm_pkg::*;
#(
    parameter int INPUT_FRAC_BITS = DEF_INPUT_FRAC_BITS,
    parameter int OUTPUT_INT_BITS = DEF_OUTPUT_INT_BITS,
    parameter int NUMW            = rxm_numw(DEF_INPUT_FRAC_BITS, DEF_OUTPUT_INT_BITS),
    parameter int DENW            = rxm_denw(DEF_INPUT_FRAC_BITS)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_ce,
    input  wire logic                   i_vld,
    input  wire logic [IN_BITS-1:0]     i_chr [N_CHR],
    output t_ctl                        o_ctl,
    output logic signed [NUMW-1:0]      o_num [9],
    output logic signed [DENW-1:0]      o_den,
    output logic signed [NUMW-1:0]      o_wnum [3],
    output logic signed [DENW-1:0]      o_wden
);

    localparam int MW  = rxm_mw(INPUT_FRAC_BITS);
    localparam int AW  = rxm_aw(INPUT_FRAC_BITS);
    localparam int DW  = rxm_dw(INPUT_FRAC_BITS);
    localparam int OF  = VAL_BITS - OUTPUT_INT_BITS;
    localparam int PW  = AW + MW;
    localparam int PNW = DW + MW;
    localparam logic signed [MW-1:0] UNIT = MW'(1) <<< INPUT_FRAC_BITS;

    logic [5:0] r_vld;

    logic signed [MW-1:0]   n_m1 [9];
    logic signed [MW-1:0]   n_w1 [3];
    logic signed [MW-1:0]   r_m1 [9], r_m2 [9], r_m3 [9], r_m4 [9], r_m5 [9];
    logic signed [MW-1:0]   r_w1 [3], r_w2 [3], r_w3 [3], r_w4 [3], r_w5 [3], r_w6 [3];
    logic signed [2*MW-1:0] n_pa2 [9], n_pb2 [9];
    logic signed [2*MW-1:0] r_pa2 [9], r_pb2 [9];
    logic signed [AW-1:0]   r_adj3 [9];
    logic signed [PW-1:0]   r_dp4 [3];
    logic signed [PW-1:0]   r_np4 [9];
    logic signed [DW-1:0]   r_det5;
    logic signed [DW-1:0]   r_n5 [3];
    logic signed [PNW-1:0]  r_num6 [9];
    logic signed [DENW-1:0] r_den6;
    logic                   r_sing6;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_m1[j]     = MW'(i_chr[2 + 2 * j]);
            n_m1[3 + j] = MW'(i_chr[3 + 2 * j]);
            n_m1[6 + j] = UNIT - MW'(i_chr[2 + 2 * j]) - MW'(i_chr[3 + 2 * j]);
        end
        n_w1[0] = MW'(i_chr[0]);
        n_w1[1] = MW'(i_chr[1]);
        n_w1[2] = UNIT - MW'(i_chr[0]) - MW'(i_chr[1]);
    end

    // cofactor products, m indexed row * 3 + column
    always_comb begin
        n_pa2[0] = r_m1[4] * r_m1[8];  n_pb2[0] = r_m1[5] * r_m1[7];
        n_pa2[1] = r_m1[7] * r_m1[2];  n_pb2[1] = r_m1[8] * r_m1[1];
        n_pa2[2] = r_m1[1] * r_m1[5];  n_pb2[2] = r_m1[2] * r_m1[4];
        n_pa2[3] = r_m1[5] * r_m1[6];  n_pb2[3] = r_m1[3] * r_m1[8];
        n_pa2[4] = r_m1[8] * r_m1[0];  n_pb2[4] = r_m1[6] * r_m1[2];
        n_pa2[5] = r_m1[2] * r_m1[3];  n_pb2[5] = r_m1[0] * r_m1[5];
        n_pa2[6] = r_m1[3] * r_m1[7];  n_pb2[6] = r_m1[4] * r_m1[6];
        n_pa2[7] = r_m1[6] * r_m1[1];  n_pb2[7] = r_m1[7] * r_m1[0];
        n_pa2[8] = r_m1[0] * r_m1[4];  n_pb2[8] = r_m1[1] * r_m1[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_m1 <= n_m1;
            r_w1 <= n_w1;
            r_pa2 <= n_pa2;
            r_pb2 <= n_pb2;
            r_m2 <= r_m1;
            r_w2 <= r_w1;
            for (int k = 0; k < 9; k++) begin
                r_adj3[k] <= AW'(r_pa2[k]) - AW'(r_pb2[k]);
            end
            r_m3 <= r_m2;
            r_w3 <= r_w2;
            for (int k = 0; k < 3; k++) begin
                r_dp4[k] <= PW'(r_adj3[3 * k]) * PW'(r_m3[k]);
                for (int c = 0; c < 3; c++) begin
                    r_np4[3 * k + c] <= PW'(r_adj3[3 * k + c]) * PW'(r_w3[c]);
                end
            end
            r_m4 <= r_m3;
            r_w4 <= r_w3;
            r_det5 <= DW'(r_dp4[0]) + DW'(r_dp4[1]) + DW'(r_dp4[2]);
            for (int k = 0; k < 3; k++) begin
                r_n5[k] <= DW'(r_np4[3 * k]) + DW'(r_np4[3 * k + 1]) + DW'(r_np4[3 * k + 2]);
            end
            r_m5 <= r_m4;
            r_w5 <= r_w4;
            for (int k = 0; k < 9; k++) begin
                r_num6[k] <= PNW'(r_n5[k % 3]) * PNW'(r_m5[k]);
            end
            r_den6  <= DENW'(r_det5) * DENW'(r_w5[1]);
            r_sing6 <= (r_det5 == '0) || (r_w5[1] == '0);
            r_w6    <= r_w5;
        end
    end

    always_comb begin
        o_ctl.vld  = r_vld[5];
        o_ctl.sing = r_sing6;
        for (int k = 0; k < 9; k++) begin
            o_num[k] = NUMW'(r_num6[k]) <<< OF;
        end
        for (int k = 0; k < 3; k++) begin
            o_wnum[k] = NUMW'(r_w6[k]) <<< OF;
        end
        o_den  = r_den6;
        o_wden = DENW'(r_w6[1]);
    end

endmodule
`default_nettype wire

// ===== rtl/rxm_div.sv =====
`default_nettype none
module rxm_div
    import rxm_pkg::*;
#(
    parameter int NUMW = rxm_numw(DEF_INPUT_FRAC_BITS, DEF_OUTPUT_INT_BITS),
    parameter int DENW = rxm_denw(DEF_INPUT_FRAC_BITS)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_ce,
    input  wire logic signed [NUMW-1:0]     i_num,
    input  wire logic signed [DENW-1:0]     i_den,
    output logic signed [VAL_BITS-1:0]      o_val
);

    localparam int QB  = VAL_BITS;
    localparam int MXW = (NUMW > DENW) ? NUMW : DENW;
    localparam int DBW = DENW + 1;
    localparam int RW  = ((MXW + 2) > (DBW + QB + 1)) ? (MXW + 2) : (DBW + QB + 1);
    localparam logic [QB-1:0] LIM_POS = {1'b0, {(QB - 1){1'b1}}};
    localparam logic [QB-1:0] LIM_NEG = {1'b1, {(QB - 1){1'b0}}};

    logic signed [RW-1:0] ns, ds;
    logic [RW-1:0] nab, dab;
    logic [RW-1:0] r_n0, r_d0;
    logic          r_neg0;

    logic [RW-1:0] r_rem [QB+1];
    logic [RW-1:0] r_d   [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];

    logic [RW-1:0] n_rem [QB];
    logic [QB-1:0] n_q   [QB];
    logic [RW-1:0] dsh;
    logic [QB-1:0] lim, mag;

    always_comb begin
        ns  = RW'(i_num);
        ds  = RW'(i_den);
        nab = ns[RW-1] ? RW'(-ns) : RW'(ns);
        dab = ds[RW-1] ? RW'(-ds) : RW'(ds);
    end

    // restoring division, one quotient bit per stage, MSB first
    always_comb begin
        for (int s = 0; s < QB; s++) begin
            dsh      = r_d[s] << (QB - 1 - s);
            n_q[s]   = r_q[s];
            if (r_rem[s] >= dsh) begin
                n_rem[s] = r_rem[s] - dsh;
                n_q[s][QB - 1 - s] = 1'b1;
            end else begin
                n_rem[s] = r_rem[s];
            end
        end
    end

    always_comb begin
        lim = r_neg[QB] ? LIM_NEG : LIM_POS;
        mag = (r_ovf[QB] || (r_q[QB] > lim)) ? lim : r_q[QB];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // rounding: (2|n| + |d|) / (2|d|), halves away from zero
            r_n0   <= (nab << 1) + dab;
            r_d0   <= dab << 1;
            r_neg0 <= i_num[NUMW-1] ^ i_den[DENW-1];

            r_rem[0] <= r_n0;
            r_d[0]   <= r_d0;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg0;
            r_ovf[0] <= r_n0 >= (r_d0 << QB);

            for (int s = 0; s < QB; s++) begin
                r_rem[s + 1] <= n_rem[s];
                r_d[s + 1]   <= r_d[s];
                r_q[s + 1]   <= n_q[s];
                r_neg[s + 1] <= r_neg[s];
                r_ovf[s + 1] <= r_ovf[s];
            end

            o_val <= r_neg[QB] ? -$signed(mag) : $signed(mag);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rxm_out.sv =====
`default_nettype none
module rxm_out
    import rxm_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_ctl                       i_ctl,
    input  wire logic signed [VAL_BITS-1:0] i_val [12],
    output logic                            o_take,
    output logic                            o_tvalid,
    input  wire logic                       i_tready,
    output logic [TDATA_OUT_W-1:0]          o_tdata,
    output logic                            o_tlast,
    output logic [TUSER_OUT_W-1:0]          o_tuser
);

    logic                       r_busy;
    logic [1:0]                 r_row;
    logic                       r_sing;
    logic signed [VAL_BITS-1:0] r_val [4][3];
    logic                       last_row;

    assign last_row = r_sing || (r_row == ROW_WHITE);
    assign o_take   = i_ctl.vld && (!r_busy || (i_tready && last_row));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_FIRST;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_row  <= ROW_FIRST;
        end else if (r_busy && i_tready) begin
            if (last_row) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_sing <= i_ctl.sing;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_val[r][c] <= i_val[3 * r + c];
                end
            end
        end
    end

    always_comb begin
        o_tvalid = r_busy;
        o_tlast  = last_row;
        o_tuser  = {r_sing, r_row};
        if (r_sing) begin
            o_tdata = '0;
        end else begin
            o_tdata = {{(TDATA_OUT_W - 3 * VAL_BITS){1'b0}},
                       r_val[r_row][2], r_val[r_row][1], r_val[r_row][0]};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rgb_to_xyz_matrix_from_primaries_unit.sv =====
`default_nettype none
// RGB-to-XYZ matrix from the xy chromaticities of a white point and three primaries.
// Input stream (s_axis): one transfer carries all eight chromaticities, unsigned Q0.16.
// Output stream (m_axis): four transfers per input, matrix rows X, Y, Z and then the
// white XYZ, each with three signed Q4.16 values rounded and saturated. tlast marks
// the fourth. A singular primaries matrix or a zero white y gives one transfer with
// zero values, tuser singular bit set and tlast high.
// From an input transfer to the first output transfer the data passes the registered
// stages of products and sums, the pipelined restoring dividers (one quotient bit
// per stage) and one output register.
// Each input needs four output transfers (one when it is singular); the output port
// moves one row per cycle while m_axis_tready is high and takes the next input as
// its last row goes out. The pipeline holds up to thirty items in flight.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the last stage holds an item that the output cannot take, the whole pipeline
// holds and s_axis_tready is low. Nothing is dropped or repeated.
module rgb_to_xyz_matrix_from_primaries_unit
    import rxm_pkg::*;
#(
    parameter int INPUT_FRAC_BITS = DEF_INPUT_FRAC_BITS,
    parameter int OUTPUT_INT_BITS = DEF_OUTPUT_INT_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // white_x, white_y, red_x, red_y, green_x, green_y, blue_x, blue_y
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // first_value, second_value, third_value, 4 zero bits
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast,
    // row_index, singular
    output logic [TUSER_OUT_W-1:0]      m_axis_tuser
);

    localparam int NUMW    = rxm_numw(INPUT_FRAC_BITS, OUTPUT_INT_BITS);
    localparam int DENW    = rxm_denw(INPUT_FRAC_BITS);
    localparam int DIV_LAT = VAL_BITS + 3;

    logic                       ce, take;
    logic [IN_BITS-1:0]         chr [N_CHR];
    t_ctl                       front_ctl;
    logic signed [NUMW-1:0]     num [9];
    logic signed [NUMW-1:0]     wnum [3];
    logic signed [DENW-1:0]     den, wden;
    logic signed [VAL_BITS-1:0] val [12];
    t_ctl                       r_side [DIV_LAT];

    always_comb begin
        for (int k = 0; k < N_CHR; k++) begin
            chr[k] = s_axis_tdata[k * IN_BITS +: IN_BITS];
        end
    end

    // advance everything unless the last stage holds an item the output cannot take
    assign ce            = !r_side[DIV_LAT-1].vld || take;
    assign s_axis_tready = ce;

    rxm_front #(
        .INPUT_FRAC_BITS (INPUT_FRAC_BITS),
        .OUTPUT_INT_BITS (OUTPUT_INT_BITS),
        .NUMW            (NUMW),
        .DENW            (DENW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (s_axis_tvalid),
        .i_chr   (chr),
        .o_ctl   (front_ctl),
        .o_num   (num),
        .o_den   (den),
        .o_wnum  (wnum),
        .o_wden  (wden)
    );

    for (genvar g = 0; g < 12; g++) begin : g_div
        rxm_div #(
            .NUMW (NUMW),
            .DENW (DENW)
        ) u_div (
            .i_clk (i_clk),
            .i_ce  (ce),
            .i_num ((g < 9) ? num[g % 9] : wnum[g % 3]),
            .i_den ((g < 9) ? den : wden),
            .o_val (val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_LAT; s++) begin
                r_side[s].vld <= 1'b0;
            end
        end else if (ce) begin
            r_side[0] <= front_ctl;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_side[s] <= r_side[s - 1];
            end
        end
    end

    rxm_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_side[DIV_LAT-1]),
        .i_val    (val),
        .o_take   (take),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
